/* hdl/wgo_pkg.sv */
package wgo_pkg;

  localparam int MAX_ADDR_W = 22;
  localparam int FIFO_DEPTH = 4;
  localparam logic [7:0] DECAY_RESET = 8'd6;
  localparam logic [7:0] PLOT_BIAS = 8'd192;
  localparam logic [16:0] SMALL_LIMIT = 17'd128;

  localparam logic [1:0] OP_DECAY = 2'd0;
  localparam logic [1:0] OP_PLOT = 2'd1;
  localparam logic [1:0] OP_BLEND = 2'd2;

  typedef enum logic [1:0] {
    K_DECAY,
    K_PLOT,
    K_BLEND
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic [MAX_ADDR_W-1:0] addr0;
    logic [MAX_ADDR_W-1:0] addr1;
    logic [7:0] val0;
    logic [7:0] val1;
    logic zero;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_status_t;

  function automatic logic [7:0] sat_add(input logic [7:0] c, input logic [7:0] g);
    logic [8:0] s;
    s = {1'b0, c} + {1'b0, g};
    return s[8] ? 8'hff : s[7:0];
  endfunction

endpackage

/* hdl/waveform_glow_overlay.sv */
// Glow overlay for an audio waveform display. After reset the store is cleared one entry per
// cycle, during which no transaction is accepted. Transactions enter a four-deep command
// queue and are executed one at a time by a unit built around the store's single write port:
// a blend steps through a store read, an output load and the release of the output register,
// a plot writes its two store entries, and a decay rewrites all GLOW_ROWS * LINE_WIDTH store
// entries, one store entry per cycle.
module waveform_glow_overlay
  import wgo_pkg::*;
#(
  parameter int LINE_WIDTH = 640,
  parameter int GLOW_ROWS = 160
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // row[7:0], column[17:8], left_sample[33:18], right_sample[49:34],
  // bg_red[57:50], bg_green[65:58], bg_blue[73:66], zero fill above.
  input  logic [79:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16]
  output logic [23:0] m_tdata,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0] decay_offset;
  logic push;
  cmd_t push_cmd;
  cmd_t head;
  logic full;
  logic empty;
  back_status_t status;

  assign s_tready = !full && !status.clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_offset <= DECAY_RESET;
    end else if (cfg_we) begin
      decay_offset <= cfg_wdata;
    end
  end

  wgo_front #(.LINE_WIDTH(LINE_WIDTH), .GLOW_ROWS(GLOW_ROWS)) u_front (
    .valid(s_tvalid),
    .room(s_tready),
    .operation(s_tuser),
    .row(s_tdata[7:0]),
    .column(s_tdata[17:8]),
    .left_sample(s_tdata[33:18]),
    .right_sample(s_tdata[49:34]),
    .bg_red(s_tdata[57:50]),
    .bg_green(s_tdata[65:58]),
    .bg_blue(s_tdata[73:66]),
    .push(push),
    .cmd(push_cmd)
  );

  wgo_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_cmd(push_cmd),
    .pop(status.pop),
    .head(head),
    .full(full),
    .empty(empty)
  );

  wgo_back #(.LINE_WIDTH(LINE_WIDTH), .GLOW_ROWS(GLOW_ROWS)) u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .empty(empty),
    .decay_offset(decay_offset),
    .status(status),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue written while full");
  a_pop_data: assert property (@(posedge clk) disable iff (rst) status.pop |-> !empty)
    else $error("command queue read while empty");
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !s_tready && !m_tvalid)
    else $error("transaction possible during store clearing");

endmodule

/* hdl/wgo_ram.sv */
module wgo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

/* hdl/wgo_fifo.sv */
module wgo_fifo
  import wgo_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  localparam int PW = $clog2(FIFO_DEPTH);

  cmd_t slots [FIFO_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0] count;

  assign full = (count == (PW+1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign head = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/wgo_front.sv */
module wgo_front
  import wgo_pkg::*;
#(
  parameter int LINE_WIDTH = 640,
  parameter int GLOW_ROWS = 160
) (
  input  logic        valid,
  input  logic        room,
  input  logic [1:0]  operation,
  input  logic [7:0]  row,
  input  logic [9:0]  column,
  input  logic [15:0] left_sample,
  input  logic [15:0] right_sample,
  input  logic [7:0]  bg_red,
  input  logic [7:0]  bg_green,
  input  logic [7:0]  bg_blue,
  output logic        push,
  output cmd_t        cmd
);

  localparam int RW = $clog2(GLOW_ROWS);
  localparam int HALF = GLOW_ROWS / 2;

  logic [16:0] mag_l;
  logic [16:0] mag_r;
  logic [7:0] sh_l;
  logic [7:0] sh_r;
  logic [RW-1:0] row0;
  logic [RW-1:0] row1;
  logic col_ok;
  logic row_ok;

  always_comb begin
    mag_l = left_sample[15] ? 17'(~{1'b1, left_sample} + 17'd1) : {1'b0, left_sample};
    mag_r = right_sample[15] ? 17'(~{1'b1, right_sample} + 17'd1) : {1'b0, right_sample};
    sh_l = mag_l[16:9];
    sh_r = mag_r[16:9];
    col_ok = int'(column) < LINE_WIDTH;
    row_ok = int'(row) < GLOW_ROWS;

    if (int'(sh_l) > HALF - 1) begin
      row0 = '0;
    end else begin
      row0 = RW'(HALF - 1 - int'(sh_l));
    end
    if (HALF + int'(sh_r) > GLOW_ROWS - 1) begin
      row1 = RW'(GLOW_ROWS - 1);
    end else begin
      row1 = RW'(HALF + int'(sh_r));
    end
    if (operation == OP_BLEND) begin
      row0 = row_ok ? RW'(row) : '0;
    end

    cmd.addr0 = MAX_ADDR_W'(int'(row0) * LINE_WIDTH + int'(column));
    cmd.addr1 = MAX_ADDR_W'(int'(row1) * LINE_WIDTH + int'(column));
    cmd.val0 = (mag_l > SMALL_LIMIT) ? 8'(sh_l + PLOT_BIAS) : mag_l[7:0];
    cmd.val1 = (mag_r > SMALL_LIMIT) ? 8'(sh_r + PLOT_BIAS) : mag_r[7:0];
    cmd.zero = !(row_ok && col_ok);
    cmd.red = bg_red;
    cmd.green = bg_green;
    cmd.blue = bg_blue;

    case (operation)
      OP_DECAY: begin
        cmd.kind = K_DECAY;
        push = valid && room;
      end
      OP_PLOT: begin
        cmd.kind = K_PLOT;
        push = valid && room && col_ok;
      end
      OP_BLEND: begin
        cmd.kind = K_BLEND;
        push = valid && room;
      end
      default: begin
        cmd.kind = K_DECAY;
        push = 1'b0;
      end
    endcase
  end

endmodule

/* hdl/wgo_back.sv */
module wgo_back
  import wgo_pkg::*;
#(
  parameter int LINE_WIDTH = 640,
  parameter int GLOW_ROWS = 160
) (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         head,
  input  logic         empty,
  input  logic [7:0]   decay_offset,
  output back_status_t status,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [23:0]  m_tdata
);

  localparam int DEPTH = GLOW_ROWS * LINE_WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(LINE_WIDTH);
  localparam int HALF = GLOW_ROWS / 2;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0] A_LAST = AW'((HALF - 1) * LINE_WIDTH - 1);
  localparam logic [AW-1:0] B_FIRST = AW'((GLOW_ROWS - 1) * LINE_WIDTH);
  localparam logic [AW-1:0] B_LAST = AW'(HALF * LINE_WIDTH - 1);
  localparam logic [AW-1:0] ROW_STEP = AW'(LINE_WIDTH);
  localparam logic [AW-1:0] BACK_STEP = AW'(2 * LINE_WIDTH - 1);
  localparam logic [CW-1:0] X_LAST = CW'(LINE_WIDTH - 1);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    DECAY_A,
    DECAY_B,
    DRAIN,
    PLOT2,
    BLEND_WAIT
  } state_t;

  state_t state;
  logic [AW-1:0] addr;
  logic [CW-1:0] x;
  logic wpend;
  logic [AW-1:0] wpend_addr;
  logic [AW-1:0] hold_addr;
  logic [7:0] hold_val;
  logic hold_zero;
  logic [7:0] hold_red;
  logic [7:0] hold_green;
  logic [7:0] hold_blue;

  logic pop;
  logic we;
  logic [AW-1:0] waddr;
  logic [7:0] wdata;
  logic [AW-1:0] raddr0;
  logic [AW-1:0] raddr1;
  logic [7:0] rdata0;
  logic [7:0] rdata1;
  logic [7:0] half_sum;
  logic [7:0] glow;

  wgo_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk(clk),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr0(raddr0),
    .rdata0(rdata0),
    .raddr1(raddr1),
    .rdata1(rdata1)
  );

  assign pop = (state == IDLE) && !empty && (head.kind != K_BLEND || !m_tvalid);
  assign status.pop = pop;
  assign status.clearing = (state == CLEAR);

  always_comb begin
    half_sum = {1'b0, rdata0[7:1]} + {1'b0, rdata1[7:1]};
    glow = hold_zero ? 8'd0 : rdata0;
    raddr0 = (state == IDLE) ? head.addr0[AW-1:0] : addr;
    raddr1 = (state == DECAY_A) ? addr + ROW_STEP : addr - ROW_STEP;

    we = 1'b0;
    waddr = addr;
    wdata = 8'd0;
    if (wpend) begin
      we = 1'b1;
      waddr = wpend_addr;
      wdata = (half_sum < decay_offset) ? 8'd0 : half_sum - decay_offset;
    end else if (state == CLEAR) begin
      we = 1'b1;
    end else if (pop && head.kind == K_PLOT) begin
      we = 1'b1;
      waddr = head.addr0[AW-1:0];
      wdata = head.val0;
    end else if (state == PLOT2) begin
      we = 1'b1;
      waddr = hold_addr;
      wdata = hold_val;
    end
  end

  always_ff @(posedge clk) begin
    wpend_addr <= addr;
    if (pop) begin
      hold_addr <= head.addr1[AW-1:0];
      hold_val <= head.val1;
      hold_zero <= head.zero;
      hold_red <= head.red;
      hold_green <= head.green;
      hold_blue <= head.blue;
    end
    if (state == BLEND_WAIT) begin
      m_tdata <= {sat_add(hold_blue, glow), sat_add(hold_green, glow),
                  sat_add(hold_red, glow)};
    end
    if (rst) begin
      state <= CLEAR;
      addr <= '0;
      x <= '0;
      wpend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      wpend <= (state == DECAY_A) || (state == DECAY_B);
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          if (addr == LAST_ADDR) begin
            addr <= '0;
            state <= IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        IDLE: begin
          if (pop) begin
            case (head.kind)
              K_DECAY: begin
                addr <= '0;
                state <= DECAY_A;
              end
              K_PLOT: state <= PLOT2;
              K_BLEND: state <= BLEND_WAIT;
              default: state <= IDLE;
            endcase
          end
        end
        DECAY_A: begin
          if (addr == A_LAST) begin
            addr <= B_FIRST;
            x <= '0;
            state <= DECAY_B;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        DECAY_B: begin
          if (addr == B_LAST) begin
            state <= DRAIN;
          end else if (x == X_LAST) begin
            x <= '0;
            addr <= addr - BACK_STEP;
          end else begin
            x <= x + 1'b1;
            addr <= addr + 1'b1;
          end
        end
        DRAIN: state <= IDLE;
        PLOT2: state <= IDLE;
        BLEND_WAIT: begin
          m_tvalid <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/tb_waveform_glow_overlay.sv */
module tb_waveform_glow_overlay
  import wgo_pkg::*;
;

  localparam int COLS = 640;
  localparam int ROWS = 160;
  localparam int HALF = ROWS / 2;
  localparam int STALL_LIMIT = 300000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class glow_scoreboard;
    bit [7:0] glow [ROWS][COLS];
    bit [7:0] offset;
    bit [23:0] pending_pixels[$];
    int mismatches;
    int blends_seen;

    function new();
      offset = DECAY_RESET;
      mismatches = 0;
      blends_seen = 0;
    endfunction

    function bit [7:0] fade(bit [7:0] self_v, bit [7:0] other_v);
      int v;
      v = int'(self_v >> 1) + int'(other_v >> 1) - int'(offset);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
    endfunction

    function bit [7:0] plot_level(int m);
      bit [7:0] v;
      v = (m > 128) ? 8'((m >> 9) + 192) : m[7:0];
      return v;
    endfunction

    function bit [7:0] add_sat(bit [7:0] c, bit [7:0] g);
      bit [8:0] s;
      s = c + g;
      return s[8] ? 8'hff : s[7:0];
    endfunction

    function void note(bit [1:0] op, bit [79:0] d);
      bit [7:0] row;
      bit [9:0] col;
      int a, b, ra, rb;
      bit [7:0] g;
      row = d[7:0];
      col = d[17:8];
      if (op == OP_DECAY) begin
        for (int y = 0; y <= HALF - 2; y++)
          for (int x = 0; x < COLS; x++) glow[y][x] = fade(glow[y][x], glow[y+1][x]);
        for (int y = ROWS - 1; y >= HALF - 1; y--)
          for (int x = 0; x < COLS; x++) glow[y][x] = fade(glow[y][x], glow[y-1][x]);
      end else if (op == OP_PLOT) begin
        if (col < COLS) begin
          a = $signed(d[33:18]);
          b = $signed(d[49:34]);
          if (a < 0) a = -a;
          if (b < 0) b = -b;
          ra = HALF - 1 - (a >> 9);
          rb = HALF + (b >> 9);
          if (ra < 0) ra = 0;
          if (rb > ROWS - 1) rb = ROWS - 1;
          glow[ra][col] = plot_level(a);
          glow[rb][col] = plot_level(b);
        end
      end else if (op == OP_BLEND) begin
        g = (row < ROWS && col < COLS) ? glow[row][col] : 8'd0;
        pending_pixels.push_back({add_sat(d[73:66], g), add_sat(d[65:58], g),
                                  add_sat(d[57:50], g)});
      end
    endfunction

    function void check(bit [23:0] got);
      bit [23:0] want;
      blends_seen++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected pixel %h", got);
        return;
      end
      want = pending_pixels.pop_front();
      for (int f = 0; f < 3; f++)
        if (want[8*f +: 8] !== got[8*f +: 8]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Pixel component %0d: expected %h, got %h", f, want[8*f +: 8],
                     got[8*f +: 8]);
        end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [23:0] m_tdata;
  logic cfg_we = 0;
  logic [7:0] cfg_wdata = '0;

  glow_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int decays_sent = 0;
  int stall_cycles = 0;

  waveform_glow_overlay DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check(m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(bit [1:0] op, bit [7:0] row, bit [9:0] col, bit [15:0] l,
                      bit [15:0] r, bit [7:0] br, bit [7:0] bg, bit [7:0] bb);
    bit [79:0] d;
    d = {6'd0, bb, bg, br, r, l, col, row};
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= d;
    s_tuser <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note(op, d);
    items_sent++;
    if (op == OP_DECAY) decays_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending_pixels.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_offset(bit [7:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    sb.offset = v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_phase(int count);
    int decays_left;
    int pick;
    bit [9:0] col;
    bit [15:0] l, r;
    decays_left = 1;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      col = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
      l = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 256) - 128) : 16'($urandom);
      r = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 256) - 128) : 16'($urandom);
      if (pick == 0 && decays_left > 0 && i > count / 3) begin
        decays_left--;
        send(OP_DECAY, 8'($urandom), col, l, r, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 5) begin
        send(OP_UNUSED, 8'($urandom), col, l, r, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 45) begin
        send(OP_PLOT, 8'($urandom), col, l, r, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send(OP_BLEND, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 159)),
             col, l, r, 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    send(OP_BLEND, 8'($urandom_range(0, 159)), 10'($urandom_range(0, 15)), 16'($urandom),
         16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 0;

    // Directed: sample extremes, clamp thresholds, edge columns, out-of-store blends.
    send(OP_PLOT, 8'd0, 10'd0, 16'h8000, 16'h7fff, 8'd0, 8'd0, 8'd0);
    send(OP_PLOT, 8'd0, 10'd639, 16'd128, 16'hff7f, 8'd0, 8'd0, 8'd0);
    send(OP_PLOT, 8'd0, 10'd1, 16'd129, 16'hffff, 8'd0, 8'd0, 8'd0);
    send(OP_PLOT, 8'd0, 10'd640, 16'd100, 16'd100, 8'd0, 8'd0, 8'd0);
    send(OP_PLOT, 8'hff, 10'd1023, 16'h7fff, 16'h8000, 8'hff, 8'hff, 8'hff);
    send(OP_BLEND, 8'd15, 10'd0, 16'd0, 16'd0, 8'd10, 8'd100, 8'd255);
    send(OP_BLEND, 8'd144, 10'd0, 16'd0, 16'd0, 8'd0, 8'd63, 8'd200);
    send(OP_BLEND, 8'd79, 10'd639, 16'd0, 16'd0, 8'd127, 8'd128, 8'd0);
    send(OP_BLEND, 8'd80, 10'd639, 16'd0, 16'd0, 8'd255, 8'd255, 8'd255);
    send(OP_BLEND, 8'd79, 10'd1, 16'd0, 16'd0, 8'd1, 8'd2, 8'd3);
    send(OP_BLEND, 8'd80, 10'd1, 16'd0, 16'd0, 8'd4, 8'd5, 8'd6);
    send(OP_BLEND, 8'd79, 10'd640, 16'd0, 16'd0, 8'd7, 8'd8, 8'd9);
    send(OP_BLEND, 8'd160, 10'd0, 16'd0, 16'd0, 8'd11, 8'd12, 8'd13);
    send(OP_BLEND, 8'd255, 10'd1023, 16'hffff, 16'hffff, 8'd200, 8'd201, 8'd202);
    send(OP_UNUSED, 8'd15, 10'd0, 16'h8000, 16'h8000, 8'd0, 8'd0, 8'd0);
    send(OP_DECAY, 8'd0, 10'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
    send(OP_BLEND, 8'd16, 10'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
    send(OP_BLEND, 8'd143, 10'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
    send(OP_BLEND, 8'd78, 10'd1, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
    drain();

    write_offset(8'd0);
    send_idle_pct = 16;
    recv_idle_pct = 78;
    random_phase(340);
    drain();

    write_offset(8'd255);
    send_idle_pct = 78;
    recv_idle_pct = 16;
    random_phase(340);
    drain();

    write_offset(8'($urandom_range(1, 254)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(340);
    drain();

    $display("Sent %0d transactions (%0d store decays) over four offset settings,",
             items_sent, decays_sent);
    $display("checked %0d blended pixels with %0d mismatches.", sb.blends_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
